// ----- design/biquad_iir_tdf2_macros.svh -----
// Assertion helpers shared by the checker files.
`ifndef BIQUAD_IIR_TDF2_MACROS_SVH
`define BIQUAD_IIR_TDF2_MACROS_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define BQ_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define BQ_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- design/bq_pkg.sv -----
package bq_pkg;

    // Coefficient register file
    localparam int CFG_INDEX_W = 3;
    localparam int NUM_COEFS   = 5;

    localparam logic [CFG_INDEX_W-1:0] COEF_B0 = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] COEF_B1 = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] COEF_B2 = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] COEF_A1 = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] COEF_A2 = 3'd4;

    // Microprogram steps
    localparam int STEP_W = 4;

    localparam logic [STEP_W-1:0] ST_IN     = 4'd0;
    localparam logic [STEP_W-1:0] ST_MUL_B0 = 4'd1;
    localparam logic [STEP_W-1:0] ST_ADD_D0 = 4'd2;
    localparam logic [STEP_W-1:0] ST_RND    = 4'd3;
    localparam logic [STEP_W-1:0] ST_SAT    = 4'd4;
    localparam logic [STEP_W-1:0] ST_OUT    = 4'd5;
    localparam logic [STEP_W-1:0] ST_MUL_B1 = 4'd6;
    localparam logic [STEP_W-1:0] ST_ADD_D1 = 4'd7;
    localparam logic [STEP_W-1:0] ST_MUL_A1 = 4'd8;
    localparam logic [STEP_W-1:0] ST_ACC_A1 = 4'd9;
    localparam logic [STEP_W-1:0] ST_WR_D0  = 4'd10;
    localparam logic [STEP_W-1:0] ST_MUL_B2 = 4'd11;
    localparam logic [STEP_W-1:0] ST_LD_B2  = 4'd12;
    localparam logic [STEP_W-1:0] ST_MUL_A2 = 4'd13;
    localparam logic [STEP_W-1:0] ST_ACC_A2 = 4'd14;
    localparam logic [STEP_W-1:0] ST_WR_D1  = 4'd15;

    typedef enum logic [1:0] {
        J_NEXT,
        J_WAIT_IN,
        J_WAIT_OUT,
        J_START
    } jump_t;

    typedef enum logic {
        MUL_X,
        MUL_Y
    } mul_src_t;

    typedef enum logic {
        ADD_A_PROD,
        ADD_A_ACC
    } add_a_t;

    typedef enum logic [2:0] {
        ADD_B_ZERO,
        ADD_B_D0,
        ADD_B_D1,
        ADD_B_PROD,
        ADD_B_HALF
    } add_b_t;

    typedef struct packed {
        jump_t                   jump;
        logic                    mul_en;
        mul_src_t                mul_src;
        logic [CFG_INDEX_W-1:0]  mul_coef;
        logic                    acc_en;
        add_a_t                  add_a;
        add_b_t                  add_b;
        logic                    y_en;
        logic                    d0_en;
        logic                    d1_en;
    } ucode_t;

    // Control store
    function automatic ucode_t ucode_rom(input logic [STEP_W-1:0] step);
        ucode_t uc;
        uc = '0;
        unique case (step)
            ST_IN:     uc.jump = J_WAIT_IN;
            ST_MUL_B0: begin uc.mul_en = 1'b1; uc.mul_src = MUL_X; uc.mul_coef = COEF_B0; end
            ST_ADD_D0: begin uc.acc_en = 1'b1; uc.add_a = ADD_A_PROD; uc.add_b = ADD_B_D0; end
            ST_RND:    begin uc.acc_en = 1'b1; uc.add_a = ADD_A_ACC; uc.add_b = ADD_B_HALF; end
            ST_SAT:    uc.y_en = 1'b1;
            ST_OUT:    uc.jump = J_WAIT_OUT;
            ST_MUL_B1: begin uc.mul_en = 1'b1; uc.mul_src = MUL_X; uc.mul_coef = COEF_B1; end
            ST_ADD_D1: begin uc.acc_en = 1'b1; uc.add_a = ADD_A_PROD; uc.add_b = ADD_B_D1; end
            ST_MUL_A1: begin uc.mul_en = 1'b1; uc.mul_src = MUL_Y; uc.mul_coef = COEF_A1; end
            ST_ACC_A1: begin uc.acc_en = 1'b1; uc.add_a = ADD_A_ACC; uc.add_b = ADD_B_PROD; end
            ST_WR_D0:  uc.d0_en = 1'b1;
            ST_MUL_B2: begin uc.mul_en = 1'b1; uc.mul_src = MUL_X; uc.mul_coef = COEF_B2; end
            ST_LD_B2:  begin uc.acc_en = 1'b1; uc.add_a = ADD_A_PROD; uc.add_b = ADD_B_ZERO; end
            ST_MUL_A2: begin uc.mul_en = 1'b1; uc.mul_src = MUL_Y; uc.mul_coef = COEF_A2; end
            ST_ACC_A2: begin uc.acc_en = 1'b1; uc.add_a = ADD_A_ACC; uc.add_b = ADD_B_PROD; end
            ST_WR_D1:  begin uc.d1_en = 1'b1; uc.jump = J_START; end
            default:   uc.jump = J_START;
        endcase
        return uc;
    endfunction

endpackage

// ----- design/biquad_iir_tdf2.sv -----
// Channel   Direction  Handshake              Payload
// cfg       in         cfg_we                 cfg_index, cfg_data (coefficient write)
// in        in         in_valid / in_ready    sample_in
// out       out        out_valid / out_ready  sample_out, clipped
//
// The step counter walks a 16-word control store, sharing one multiplier and
// one adder over five products.
// The program holds at the output step while the previous result still waits.
// A new item is taken while the last result sits in the output register.
// rst_n clears coefficients, delays and control; any valid coefficient write
// also clears both delays.
module biquad_iir_tdf2
    import bq_pkg::*;
#(
    parameter int SAMPLE_WIDTH   = 16,
    parameter int COEF_WIDTH     = 24,
    parameter int COEF_FRAC_BITS = 20,
    parameter int ACC_WIDTH      = 44
)
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic [CFG_INDEX_W-1:0]         cfg_index,
    input  logic [COEF_WIDTH-1:0]          cfg_data,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic signed [SAMPLE_WIDTH-1:0] sample_in,
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic signed [SAMPLE_WIDTH-1:0] sample_out,
    output logic                           clipped
);

    // Product width and adder width with two guard bits, so no sum wraps.
    localparam int PROD_W = SAMPLE_WIDTH + COEF_WIDTH;
    localparam int SUM_W  = ((PROD_W > ACC_WIDTH) ? PROD_W : ACC_WIDTH) + 2;

    localparam logic signed [SUM_W-1:0] HALF =
        {{(SUM_W-1){1'b0}}, 1'b1} << (COEF_FRAC_BITS - 1);
    localparam logic signed [SUM_W-1:0] Y_MAX =
        {{(SUM_W-SAMPLE_WIDTH+1){1'b0}}, {(SAMPLE_WIDTH-1){1'b1}}};
    localparam logic signed [SUM_W-1:0] Y_MIN = ~Y_MAX;
    localparam logic signed [SUM_W-1:0] D_MAX =
        {{(SUM_W-ACC_WIDTH+1){1'b0}}, {(ACC_WIDTH-1){1'b1}}};
    localparam logic signed [SUM_W-1:0] D_MIN = ~D_MAX;

    // Sequencer
    logic [STEP_W-1:0] step_reg, step_next;
    ucode_t            uc;

    // Datapath registers
    logic signed [COEF_WIDTH-1:0]   coef_reg [NUM_COEFS];
    logic signed [ACC_WIDTH-1:0]    d0_reg, d1_reg;
    logic signed [SAMPLE_WIDTH-1:0] x_reg;
    logic signed [SAMPLE_WIDTH-1:0] y_reg, y_next;
    logic                           clip_reg, clip_next;
    logic signed [PROD_W-1:0]       prod_reg, prod_next;
    logic signed [SUM_W-1:0]        acc_reg, acc_next;

    // Output register
    logic                           out_valid_reg, out_valid_next;
    logic signed [SAMPLE_WIDTH-1:0] sample_out_reg;
    logic                           clipped_reg;

    logic                           in_take;
    logic                           out_load;
    logic                           cfg_hit;
    logic signed [SAMPLE_WIDTH-1:0] mul_a;
    logic signed [COEF_WIDTH-1:0]   mul_b;
    logic signed [SUM_W-1:0]        add_a_val, add_b_val;
    logic signed [SUM_W-1:0]        shifted;
    logic signed [ACC_WIDTH-1:0]    d_new;

    assign uc = ucode_rom(step_reg);

    // Next step: fall through, hold on a wait, or restart the program.
    always_comb
    begin
        step_next = step_reg + 1'b1;
        unique case (uc.jump)
            J_NEXT:     step_next = step_reg + 1'b1;
            J_WAIT_IN:
            begin
                if (!in_valid)
                    step_next = step_reg;
            end
            J_WAIT_OUT:
            begin
                if (out_valid_reg && !out_ready)
                    step_next = step_reg;
            end
            J_START:    step_next = ST_IN;
        endcase
    end

    // Handshake decode from the current control word
    always_comb
    begin
        in_ready = (uc.jump == J_WAIT_IN);
        in_take  = in_ready && in_valid;
        out_load = (uc.jump == J_WAIT_OUT) && !(out_valid_reg && !out_ready);
        if (out_load)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    assign cfg_hit = cfg_we && (cfg_index < CFG_INDEX_W'(NUM_COEFS));

    // Shared multiplier, registered
    always_comb
    begin
        mul_a     = (uc.mul_src == MUL_Y) ? y_reg : x_reg;
        mul_b     = coef_reg[uc.mul_coef];
        prod_next = mul_a * mul_b;
    end

    // Shared adder
    always_comb
    begin
        if (uc.add_a == ADD_A_ACC)
            add_a_val = acc_reg;
        else
            add_a_val = {{(SUM_W-PROD_W){prod_reg[PROD_W-1]}}, prod_reg};
        case (uc.add_b)
            ADD_B_D0:   add_b_val = {{(SUM_W-ACC_WIDTH){d0_reg[ACC_WIDTH-1]}}, d0_reg};
            ADD_B_D1:   add_b_val = {{(SUM_W-ACC_WIDTH){d1_reg[ACC_WIDTH-1]}}, d1_reg};
            ADD_B_PROD: add_b_val = {{(SUM_W-PROD_W){prod_reg[PROD_W-1]}}, prod_reg};
            ADD_B_HALF: add_b_val = HALF;
            default:    add_b_val = '0;
        endcase
        acc_next = add_a_val + add_b_val;
    end

    // Output: arithmetic shift (rounding offset already added), then saturate.
    always_comb
    begin
        shifted   = acc_reg >>> COEF_FRAC_BITS;
        clip_next = 1'b0;
        y_next    = shifted[SAMPLE_WIDTH-1:0];
        if (shifted > Y_MAX)
        begin
            y_next    = Y_MAX[SAMPLE_WIDTH-1:0];
            clip_next = 1'b1;
        end
        else if (shifted < Y_MIN)
        begin
            y_next    = Y_MIN[SAMPLE_WIDTH-1:0];
            clip_next = 1'b1;
        end
    end

    // Delay update saturates to the accumulator range.
    always_comb
    begin
        if (acc_reg > D_MAX)
            d_new = D_MAX[ACC_WIDTH-1:0];
        else if (acc_reg < D_MIN)
            d_new = D_MIN[ACC_WIDTH-1:0];
        else
            d_new = acc_reg[ACC_WIDTH-1:0];
    end

    // Control state, coefficients and delays
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg      <= ST_IN;
            out_valid_reg <= 1'b0;
            d0_reg        <= '0;
            d1_reg        <= '0;
            for (int i = 0; i < NUM_COEFS; i++)
                coef_reg[i] <= '0;
        end
        else
        begin
            step_reg      <= step_next;
            out_valid_reg <= out_valid_next;
            if (cfg_hit)
            begin
                coef_reg[cfg_index] <= cfg_data;
                d0_reg              <= '0;
                d1_reg              <= '0;
            end
            else
            begin
                if (uc.d0_en)
                    d0_reg <= d_new;
                if (uc.d1_en)
                    d1_reg <= d_new;
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (in_take)
            x_reg <= sample_in;
        if (uc.mul_en)
            prod_reg <= prod_next;
        if (uc.acc_en)
            acc_reg <= acc_next;
        if (uc.y_en)
        begin
            y_reg    <= y_next;
            clip_reg <= clip_next;
        end
        if (out_load)
        begin
            sample_out_reg <= y_reg;
            clipped_reg    <= clip_reg;
        end
    end

    assign out_valid  = out_valid_reg;
    assign sample_out = sample_out_reg;
    assign clipped    = clipped_reg;

endmodule

// ----- design/bq_checker.sv -----
`include "biquad_iir_tdf2_macros.svh"

module bq_checker #(
    parameter int SAMPLE_WIDTH = 16
)
(
    input logic                           clk,
    input logic                           rst_n,
    input logic                           in_valid,
    input logic                           in_ready,
    input logic                           out_valid,
    input logic                           out_ready,
    input logic signed [SAMPLE_WIDTH-1:0] sample_out,
    input logic                           clipped
);

    localparam logic signed [SAMPLE_WIDTH-1:0] OUT_MAX = {1'b0, {(SAMPLE_WIDTH-1){1'b1}}};
    localparam logic signed [SAMPLE_WIDTH-1:0] OUT_MIN = {1'b1, {(SAMPLE_WIDTH-1){1'b0}}};

    // stalled result holds
    `BQ_ASSERT_NXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(sample_out) && $stable(clipped), "stalled output item changed")
    // clip flag only with a rail value
    `BQ_ASSERT_IMP(a_clip_rail, out_valid && clipped, sample_out == OUT_MAX || sample_out == OUT_MIN, "clipped set without a saturated sample")
    // one item in flight: busy right after a take
    `BQ_ASSERT_NXT(a_busy_after_take, in_valid && in_ready, !in_ready, "input taken twice in a row")
    // ready stays up while the input side waits for an item
    `BQ_ASSERT_NXT(a_in_ready_hold, in_ready && !in_valid, in_ready, "input ready dropped with no item taken")

endmodule

bind biquad_iir_tdf2 bq_checker #(.SAMPLE_WIDTH(SAMPLE_WIDTH)) u_bq_checker (.*);

// ----- test/tb_biquad_iir_tdf2.sv -----
module tb_biquad_iir_tdf2
    import bq_pkg::*;
;

    // Block widths, left at their defaults on the instance below
    localparam int SAMPLE_W  = 16;
    localparam int COEF_W    = 24;
    localparam int FRAC_BITS = 20;
    localparam int ACC_W     = 44;

    // Q4.20 helpers and sample extremes
    localparam int ONE_Q20 = 1 << FRAC_BITS;
    localparam int COEF_MAX = 8388607;
    localparam int COEF_MIN = -8388608;
    localparam logic signed [SAMPLE_W-1:0] SAMPLE_MAX = 16'sh7FFF;
    localparam logic signed [SAMPLE_W-1:0] SAMPLE_MIN = 16'sh8000;

    // The control store still runs its delay-update steps after the result is out,
    // so SETTLE_CYCLES is a safe quiet time before touching the coefficients.
    localparam int SETTLE_CYCLES = 32;
    localparam int ITEMS_PER_SET = 200;
    localparam int CYCLE_LIMIT   = 1000000;
    localparam int MAX_REPORTS   = 10;

    logic                       clk = 1'b0;
    logic                       rst_n = 1'b0;
    logic                       cfg_we = 1'b0;
    logic [CFG_INDEX_W-1:0]     cfg_index = '0;
    logic [COEF_W-1:0]          cfg_data = '0;
    logic                       in_valid = 1'b0;
    logic                       in_ready;
    logic signed [SAMPLE_W-1:0] sample_in = '0;
    logic                       out_valid;
    logic                       out_ready = 1'b0;
    logic signed [SAMPLE_W-1:0] sample_out;
    logic                       clipped;

    int sender_idle_pct = 0;
    int receiver_idle_pct = 0;
    int cycle_count = 0;

    // One expected filtered item
    typedef struct {
        logic signed [SAMPLE_W-1:0] sample;
        logic                       clip;
    } filtered_t;

    // Tracks the filter: coefficients, both transposed delays, and the queue of
    // filtered samples still owed by the block.
    class biquad_scoreboard;
        longint    coefs[NUM_COEFS];
        longint    delay_first;
        longint    delay_second;
        filtered_t expected_q[$];
        int        errors;
        int        results_seen;

        function new();
            foreach (coefs[i]) coefs[i] = 0;
            delay_first = 0;
            delay_second = 0;
            errors = 0;
            results_seen = 0;
        endfunction

        function longint saturate(longint v, int w, output bit hit);
            longint hi;
            longint lo;
            hi = (longint'(1) <<< (w - 1)) - 1;
            lo = -hi - 1;
            hit = 1'b0;
            if (v > hi) begin
                hit = 1'b1;
                return hi;
            end
            if (v < lo) begin
                hit = 1'b1;
                return lo;
            end
            return v;
        endfunction

        // Writes to unused indexes leave everything as it is
        function void write_coef(logic [CFG_INDEX_W-1:0] idx, logic [COEF_W-1:0] data);
            if (idx < NUM_COEFS) begin
                coefs[idx] = longint'($signed(data));
                delay_first = 0;
                delay_second = 0;
            end
        endfunction

        // y = round_sat(b0*x + d0); the delays then take the saturated y
        function void note_sample(logic signed [SAMPLE_W-1:0] x);
            longint    xs;
            longint    acc;
            longint    y;
            bit        clip;
            bit        unused;
            filtered_t e;
            xs = x;
            acc = coefs[COEF_B0] * xs + delay_first + (longint'(1) <<< (FRAC_BITS - 1));
            y = saturate(acc >>> FRAC_BITS, SAMPLE_W, clip);
            delay_first = saturate(coefs[COEF_B1] * xs + coefs[COEF_A1] * y + delay_second,
                                   ACC_W, unused);
            delay_second = saturate(coefs[COEF_B2] * xs + coefs[COEF_A2] * y, ACC_W, unused);
            e.sample = y[SAMPLE_W-1:0];
            e.clip = clip;
            expected_q.push_back(e);
        endfunction

        function bit count_mismatch();
            errors++;
            return errors <= MAX_REPORTS;
        endfunction

        function void check_result(logic signed [SAMPLE_W-1:0] y, logic c);
            filtered_t e;
            results_seen++;
            if (expected_q.size() == 0) begin
                if (count_mismatch())
                    $display("result %0d with nothing pending: sample_out=%0d clipped=%0b",
                             results_seen, y, c);
                return;
            end
            e = expected_q.pop_front();
            if (y !== e.sample && count_mismatch())
                $display("result %0d sample_out: expected %0d, got %0d",
                         results_seen, e.sample, y);
            if (c !== e.clip && count_mismatch())
                $display("result %0d clipped: expected %0b, got %0b",
                         results_seen, e.clip, c);
        endfunction

        function int pending();
            return expected_q.size();
        endfunction
    endclass

    biquad_scoreboard sb = new();

    biquad_iir_tdf2 DUT (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .sample_in  (sample_in),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .sample_out (sample_out),
        .clipped    (clipped)
    );

    always #1 clk = ~clk;

    // Single reset at start of run, released on a rising edge
    initial
    begin
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
    end

    // Run length guard
    always @(posedge clk)
        cycle_count <= cycle_count + 1;

    initial
    begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("Some tests failed");
        $finish;
    end

    // Output side: check every accepted item, then pick the next ready at random.
    // Values read here are the ones settled before the edge.
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
            sb.check_result(sample_out, clipped);
        out_ready <= ($urandom_range(0, 99) >= receiver_idle_pct);
    end

    // Input side: optional idle cycles, then hold valid until the item is taken.
    // Called and returning on a rising edge; valid stays high for back-to-back items.
    task automatic send_sample(input logic signed [SAMPLE_W-1:0] x);
        while ($urandom_range(0, 99) < sender_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        sample_in <= x;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        sb.note_sample(x);
    endtask

    // Stop sending, let every owed item drain, then let the delay update finish
    task automatic wait_drained();
        in_valid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // One write per cycle; the caller lowers cfg_we after the last one
    task automatic write_coef(input logic [CFG_INDEX_W-1:0] idx, input logic [COEF_W-1:0] data);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        @(posedge clk);
        sb.write_coef(idx, data);
    endtask

    task automatic apply_coefs(input int b0, input int b1, input int b2,
                               input int a1, input int a2);
        wait_drained();
        write_coef(COEF_B0, COEF_W'(b0));
        write_coef(COEF_B1, COEF_W'(b1));
        write_coef(COEF_B2, COEF_W'(b2));
        write_coef(COEF_A1, COEF_W'(a1));
        write_coef(COEF_A2, COEF_W'(a2));
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    // Write to an index past the coefficient file; delays must survive it
    task automatic poke_unused_index();
        wait_drained();
        write_coef(CFG_INDEX_W'($urandom_range(NUM_COEFS, (1 << CFG_INDEX_W) - 1)),
                   COEF_W'($urandom()));
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    // Random poles inside the stability triangle: |a2| < 1, |a1| < 1 - a2
    // (feedback terms here are already negated)
    task automatic load_stable_set();
        int a2;
        int bound;
        int a1;
        a2 = int'($urandom_range(0, 1900000)) - 950000;
        bound = ((ONE_Q20 - a2) * 97) / 100;
        a1 = int'($urandom_range(0, 2 * bound)) - bound;
        apply_coefs(int'($urandom_range(0, 2 * ONE_Q20)) - ONE_Q20,
                    int'($urandom_range(0, 2 * ONE_Q20)) - ONE_Q20,
                    int'($urandom_range(0, 2 * ONE_Q20)) - ONE_Q20,
                    a1, a2);
    endtask

    // Mix of full-range, extreme and near-zero samples
    function automatic logic signed [SAMPLE_W-1:0] random_sample();
        case ($urandom_range(0, 9))
            0:       return SAMPLE_MAX;
            1:       return SAMPLE_MIN;
            2, 3:    return SAMPLE_W'(int'($urandom_range(0, 512)) - 256);
            default: return SAMPLE_W'($urandom());
        endcase
    endfunction

    initial
    begin
        int ph;
        int s;
        int n;

        sender_idle_pct = 6;
        receiver_idle_pct = 82;
        wait (rst_n);
        @(posedge clk);

        // Reset coefficients: all zero, output stays zero
        send_sample(SAMPLE_MAX);
        send_sample(SAMPLE_MIN);

        // Unity pass-through, including the rounding of -1
        apply_coefs(ONE_Q20, 0, 0, 0, 0);
        send_sample(SAMPLE_MAX);
        send_sample(SAMPLE_MIN);
        send_sample(16'sd1);
        send_sample(-16'sd1);

        // Half gain: exact half LSB rounds up
        apply_coefs(ONE_Q20 / 2, 0, 0, 0, 0);
        send_sample(16'sd1);
        send_sample(-16'sd1);

        // Largest positive and negative b0: clips both ways
        apply_coefs(COEF_MAX, 0, 0, 0, 0);
        send_sample(SAMPLE_MAX);
        send_sample(SAMPLE_MIN);
        send_sample(16'sd0);
        apply_coefs(COEF_MIN, 0, 0, 0, 0);
        send_sample(SAMPLE_MIN);
        send_sample(SAMPLE_MAX);

        // Every register at its extremes, feedback driven from saturated output
        apply_coefs(COEF_MAX, COEF_MAX, COEF_MAX, COEF_MAX, COEF_MAX);
        send_sample(SAMPLE_MAX);
        send_sample(SAMPLE_MAX);
        send_sample(SAMPLE_MIN);
        apply_coefs(COEF_MIN, COEF_MIN, COEF_MIN, COEF_MIN, COEF_MIN);
        send_sample(SAMPLE_MIN);
        send_sample(SAMPLE_MAX);

        // Ordinary low-pass: impulse response, with an unused-index write in the
        // middle of the tail
        apply_coefs(70779, 141558, 70779, 1198500, -432852);
        send_sample(SAMPLE_MAX);
        send_sample(16'sd0);
        send_sample(16'sd0);
        send_sample(16'sd0);
        poke_unused_index();
        send_sample(16'sd0);
        send_sample(16'sd0);
        send_sample(SAMPLE_MIN);

        // Random part: three idle patterns, three coefficient sets each.
        // One set is fully random and mostly clips.
        for (ph = 0; ph < 3; ph++)
        begin
            case (ph)
                0:
                begin
                    sender_idle_pct = 6;
                    receiver_idle_pct = 82;
                end
                1:
                begin
                    sender_idle_pct = 82;
                    receiver_idle_pct = 6;
                end
                default:
                begin
                    sender_idle_pct = 0;
                    receiver_idle_pct = 0;
                end
            endcase
            for (s = 0; s < 3; s++)
            begin
                if (ph == 1 && s == 2)
                    apply_coefs(int'($urandom()), int'($urandom()), int'($urandom()),
                                int'($urandom()), int'($urandom()));
                else
                    load_stable_set();
                for (n = 0; n < ITEMS_PER_SET; n++)
                begin
                    if (n == ITEMS_PER_SET / 2)
                        poke_unused_index();
                    send_sample(random_sample());
                end
            end
        end

        wait_drained();
        if (sb.errors == 0 && sb.pending() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
